// ===== rtl/sdes_pkg.sv =====
// ============================================================================
// S-DES CBC package
// Bit permutations, S-boxes and round functions of simplified DES on 8-bit
// blocks. All tables index bits from 0 at the LSB.
// ============================================================================
package sdes_pkg;

    localparam int KEY_W    = 10;
    localparam int BLOCK_W  = 8;
    localparam int HALF_W   = 4;
    localparam int SUBKEY_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KEY_W;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR = 2'd1;

    localparam logic [0:0] MODE_ENCRYPT = 1'b0;
    localparam logic [0:0] MODE_DECRYPT = 1'b1;

    // indexed by {row, col}
    localparam logic [1:0] S0_BOX [0:15] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] S1_BOX [0:15] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    typedef struct packed {
        logic [SUBKEY_W-1:0] k1;
        logic [SUBKEY_W-1:0] k2;
        logic [BLOCK_W-1:0]  iv;
    } key_set_t;

    function automatic logic [KEY_W-1:0] perm_p10(input logic [KEY_W-1:0] k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic logic [SUBKEY_W-1:0] perm_p8(input logic [KEY_W-1:0] x);
        return {x[4], x[7], x[3], x[6], x[2], x[5], x[0], x[1]};
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_ip(input logic [BLOCK_W-1:0] x);
        return {x[6], x[2], x[5], x[7], x[4], x[0], x[3], x[1]};
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_ipi(input logic [BLOCK_W-1:0] x);
        return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
    endfunction

    function automatic logic [SUBKEY_W-1:0] expand_ep(input logic [HALF_W-1:0] h);
        return {h[0], h[3], h[2], h[1], h[2], h[1], h[0], h[3]};
    endfunction

    function automatic logic [HALF_W-1:0] perm_p4(input logic [HALF_W-1:0] s);
        return {s[2], s[0], s[1], s[3]};
    endfunction

    function automatic logic [HALF_W-1:0] feistel(input logic [HALF_W-1:0] half,
                                                  input logic [SUBKEY_W-1:0] sk);
        logic [SUBKEY_W-1:0] x;
        logic [1:0]          s0;
        logic [1:0]          s1;
        x  = expand_ep(half) ^ sk;
        // row from outer bits, column from inner bits of each nibble
        s0 = S0_BOX[{x[7], x[4], x[6], x[5]}];
        s1 = S1_BOX[{x[3], x[0], x[2], x[1]}];
        return perm_p4({s0, s1});
    endfunction

    function automatic logic [BLOCK_W-1:0] block_pass(input logic [BLOCK_W-1:0] blk,
                                                      input logic [SUBKEY_W-1:0] ka,
                                                      input logic [SUBKEY_W-1:0] kb);
        logic [BLOCK_W-1:0] t;
        logic [HALF_W-1:0]  l1;
        logic [HALF_W-1:0]  l2;
        t  = perm_ip(blk);
        l1 = t[7:4] ^ feistel(t[3:0], ka);
        l2 = t[3:0] ^ feistel(l1, kb);
        return perm_ipi({l2, l1});
    endfunction

endpackage

// ===== rtl/sdes_keys.sv =====
// ============================================================================
// S-DES key schedule
// Holds the IV and the two round subkeys, derived from the key at write time.
// ============================================================================
module sdes_keys (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sdes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sdes_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output sdes_pkg::key_set_t             keys
);
    import sdes_pkg::*;

    logic [SUBKEY_W-1:0] k1_reg, k1_next;
    logic [SUBKEY_W-1:0] k2_reg, k2_next;
    logic [BLOCK_W-1:0]  iv_reg, iv_next;
    logic [KEY_W-1:0]    p10;
    logic [4:0]          left_r1;
    logic [4:0]          right_r1;
    logic [4:0]          left_r3;
    logic [4:0]          right_r3;

    always_comb begin
        p10      = perm_p10(cfg_wdata[KEY_W-1:0]);
        left_r1  = {p10[8:5], p10[9]};
        right_r1 = {p10[3:0], p10[4]};
        left_r3  = {left_r1[2:0], left_r1[4:3]};
        right_r3 = {right_r1[2:0], right_r1[4:3]};
        k1_next  = k1_reg;
        k2_next  = k2_reg;
        iv_next  = iv_reg;
        if (cfg_wr_en && cfg_index == REG_CIPHER_KEY) begin
            k1_next = perm_p8({left_r1, right_r1});
            k2_next = perm_p8({left_r3, right_r3});
        end
        if (cfg_wr_en && cfg_index == REG_INIT_VECTOR) begin
            iv_next = cfg_wdata[BLOCK_W-1:0];
        end
    end

    // a zero key gives zero subkeys
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg <= '0;
            k2_reg <= '0;
            iv_reg <= '0;
        end else begin
            k1_reg <= k1_next;
            k2_reg <= k2_next;
            iv_reg <= iv_next;
        end
    end

    assign keys = '{k1: k1_reg, k2: k2_reg, iv: iv_reg};

endmodule

// ===== rtl/sdes_cbc_path.sv =====
// ============================================================================
// S-DES CBC datapath
// One block pass with CBC chaining; gives the result and the next chain value.
// ============================================================================
module sdes_cbc_path (
    input  logic [sdes_pkg::BLOCK_W-1:0] data_in,
    input  logic                         mode,
    input  logic                         first_block,
    input  logic [sdes_pkg::BLOCK_W-1:0] chain_value,
    input  sdes_pkg::key_set_t           keys,
    output logic [sdes_pkg::BLOCK_W-1:0] data_out,
    output logic [sdes_pkg::BLOCK_W-1:0] chain_next
);
    import sdes_pkg::*;

    logic [BLOCK_W-1:0] prev;
    logic [BLOCK_W-1:0] enc;
    logic [BLOCK_W-1:0] dec;

    always_comb begin
        prev = first_block ? keys.iv : chain_value;
        enc  = block_pass(data_in ^ prev, keys.k1, keys.k2);
        dec  = block_pass(data_in, keys.k2, keys.k1) ^ prev;
        unique case (mode)
            MODE_DECRYPT: begin
                data_out   = dec;
                chain_next = data_in;
            end
            default: begin
                data_out   = enc;
                chain_next = enc;
            end
        endcase
    end

endmodule

// ===== rtl/sdes_cbc_cipher_top.sv =====
// ============================================================================
// S-DES CBC cipher top level
// Byte-wide simplified DES in CBC mode with an input register, a one-pass
// datapath and an output register.
// ============================================================================
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | s_valid / s_ready   | s_data_in[7:0], s_mode, s_first_block
//  result   | m_valid / m_ready   | m_data_out[7:0]
//  config   | cfg_wr_en           | cfg_index[1:0], cfg_wdata[9:0]
//
//  One transaction per cycle sustained while m_ready is high; m_valid rises
//  once a transaction has gone from the input register through the pass
//  into the output register. The chain register updates as a transaction
//  moves into the output register, and the next transaction's pass reads it.
//  Reset clears the chain, the subkeys, the IV and both valid flags.
//  A stalled m_ready holds the output register; a full input register then
//  holds too and s_ready drops.
// ============================================================================
module sdes_cbc_cipher_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sdes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sdes_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sdes_pkg::BLOCK_W-1:0]    s_data_in,
    input  logic                           s_mode,
    input  logic                           s_first_block,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sdes_pkg::BLOCK_W-1:0]    m_data_out
);
    import sdes_pkg::*;

    key_set_t           keys;
    logic               stage_valid_reg, stage_valid_next;
    logic [BLOCK_W-1:0] stage_data_reg, stage_data_next;
    logic               stage_mode_reg, stage_mode_next;
    logic               stage_first_reg, stage_first_next;
    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] out_data_reg, out_data_next;
    logic [BLOCK_W-1:0] chain_reg, chain_next;
    logic [BLOCK_W-1:0] path_result;
    logic [BLOCK_W-1:0] path_chain;
    logic               advance;
    logic               take_in;

    sdes_keys u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .keys      (keys)
    );

    sdes_cbc_path u_path (
        .data_in     (stage_data_reg),
        .mode        (stage_mode_reg),
        .first_block (stage_first_reg),
        .chain_value (chain_reg),
        .keys        (keys),
        .data_out    (path_result),
        .chain_next  (path_chain)
    );

    assign advance = stage_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        stage_data_next  = stage_data_reg;
        stage_mode_next  = stage_mode_reg;
        stage_first_next = stage_first_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        chain_next       = chain_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            stage_valid_next = 1'b0;
            out_valid_next   = 1'b1;
            out_data_next    = path_result;
            chain_next       = path_chain;
        end
        if (take_in) begin
            stage_valid_next = 1'b1;
            stage_data_next  = s_data_in;
            stage_mode_next  = s_mode;
            stage_first_next = s_first_block;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            chain_reg       <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            chain_reg       <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_data_reg  <= stage_data_next;
        stage_mode_reg  <= stage_mode_next;
        stage_first_reg <= stage_first_next;
        out_data_reg    <= out_data_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_data_out = out_data_reg;

`ifndef SYNTHESIS
    // encrypting chains on the ciphertext just produced
    a_chain_enc: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stage_mode_reg == MODE_ENCRYPT |=> chain_reg == m_data_out)
        else $error("chain register does not follow ciphertext");

    // decrypting chains on the incoming ciphertext
    a_chain_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stage_mode_reg == MODE_DECRYPT |=> chain_reg == $past(stage_data_reg))
        else $error("chain register does not follow input ciphertext");

    // a held input register must not be overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && !advance |-> !s_ready)
        else $error("input register overwritten while held");

    // a transaction in the input register reaches the output when it is free
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && (!out_valid_reg || m_ready) |=> m_valid)
        else $error("transaction lost between stages");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
